@@ rtl/core/bfaq_pkg.sv @@
// Package with shared types and constants for the Bloom filter core.
`default_nettype none
package bfaq_pkg;
    localparam int MAX_BITS     = 65536;
    localparam int MAX_HASHES   = 16;
    localparam int ADDR_W       = $clog2(MAX_BITS);
    localparam int KCNT_W       = $clog2(MAX_HASHES + 1);
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] MIX_SEED   = 32'hDEADBEEF;
    localparam logic [31:0] MIX_MUL    = 32'h045D9F3B;
    localparam logic [1:0]  REG_NUM_BITS   = 2'd0;
    localparam logic [1:0]  REG_NUM_HASHES = 2'd1;
    localparam logic        CMD_ADD   = 1'b0;
    localparam logic        CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [31:0] h1;
        logic [31:0] h2;
        logic        cmd;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PROD,
        B_MOD,
        B_ACCESS,
        B_CHECK,
        B_DONE
    } t_back_state;
endpackage
`default_nettype wire

@@ rtl/core/bfaq_if.sv @@
// Valid/ready stream interfaces for the request and result channels.
`default_nettype none
interface bfaq_req_if (input wire logic i_clk);
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, cmd, key_byte, has_byte, last, input ready);
    modport sink   (input valid, cmd, key_byte, has_byte, last, output ready);
endinterface

interface bfaq_rsp_if (input wire logic i_clk);
    logic valid;
    logic ready;
    logic was_query;
    logic maybe_present;
    modport source (output valid, was_query, maybe_present, input ready);
    modport sink   (input valid, was_query, maybe_present, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bfaq_front.sv @@
// Front end: folds key bytes into both hashes and emits a probe job per key.
`default_nettype none
module bfaq_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bfaq_req_if.sink         req,
    output bfaq_pkg::t_job   o_job,
    output logic             o_job_valid,
    input  wire logic        i_job_ready
);
    import bfaq_pkg::*;

    t_front_state r_state, n_state;
    logic [31:0]  r_fnv, n_fnv;
    logic [31:0]  r_mix, n_mix;
    logic [31:0]  r_tmp, n_tmp;
    logic         r_last, n_last;
    logic         r_cmd, n_cmd;
    logic [63:0]  w_prod_fnv;
    logic [63:0]  w_prod_mix;
    logic [31:0]  w_mix_in;

    assign w_mix_in   = r_tmp ^ (r_tmp >> 16);
    assign w_prod_mix = w_mix_in * MIX_MUL;
    assign w_prod_fnv = (r_fnv ^ {24'd0, req.key_byte}) * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fnv   <= FNV_OFFSET;
            r_mix   <= MIX_SEED;
        end else begin
            r_state <= n_state;
            r_fnv   <= n_fnv;
            r_mix   <= n_mix;
        end
        r_tmp  <= n_tmp;
        r_last <= n_last;
        r_cmd  <= n_cmd;
    end

    always_comb begin
        n_state     = r_state;
        n_fnv       = r_fnv;
        n_mix       = r_mix;
        n_tmp       = r_tmp;
        n_last      = r_last;
        n_cmd       = r_cmd;
        req.ready   = 1'b0;
        o_job_valid = 1'b0;
        o_job.h1    = r_fnv;
        o_job.h2    = r_mix;
        o_job.cmd   = r_cmd;
        unique case (r_state)
            S_IDLE: begin
                if (req.valid && !req.has_byte && req.last) begin
                    o_job_valid = 1'b1;
                    o_job.cmd   = req.cmd;
                    req.ready   = i_job_ready;
                    if (i_job_ready) begin
                        n_fnv = FNV_OFFSET;
                        n_mix = MIX_SEED;
                    end
                end else begin
                    req.ready = 1'b1;
                    if (req.valid && req.has_byte) begin
                        n_last  = req.last;
                        n_cmd   = req.cmd;
                        n_fnv   = w_prod_fnv[31:0];
                        n_tmp   = r_mix ^ {24'd0, req.key_byte};
                        n_state = S_MIX1;
                    end
                end
            end
            S_MIX1: begin
                n_tmp   = w_prod_mix[31:0];
                n_state = S_MIX2;
            end
            S_MIX2: begin
                n_tmp = w_prod_mix[31:0];
                n_mix = w_prod_mix[31:0] ^ (w_prod_mix[31:0] >> 16);
                if (r_last) begin
                    o_job_valid = 1'b1;
                    o_job.h2    = n_mix;
                    if (i_job_ready) begin
                        n_fnv   = FNV_OFFSET;
                        n_mix   = MIX_SEED;
                        n_state = S_IDLE;
                    end else begin
                        n_mix = r_mix;
                        n_tmp = r_tmp;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !req.ready) else $error("front accepted while busy");
    a_mix_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX1) |=> (r_state == S_MIX2)) else $error("mix rounds out of order");
    a_job_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (r_state == S_MIX2 || (r_state == S_IDLE && req.valid)))
        else $error("job without key end");
`endif
endmodule
`default_nettype wire

@@ rtl/core/bfaq_queue.sv @@
// Small FIFO carrying probe jobs from the front end to the back end.
`default_nettype none
module bfaq_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  bfaq_pkg::t_job   i_job,
    input  wire logic        i_valid,
    output logic             o_ready,
    output bfaq_pkg::t_job   o_job,
    output logic             o_valid,
    input  wire logic        i_ready
);
    import bfaq_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              w_push, w_pop;

    assign o_ready = (r_cnt != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end

`ifndef SYNTHESIS
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_cnt[QPTR_W-1:0]) else $error("queue pointers disagree");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

@@ rtl/core/bfaq_back.sv @@
// Back end: probe position generation, modulo unit and the filter bit store.
`default_nettype none
module bfaq_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  bfaq_pkg::t_job                  i_job,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [16:0]                i_num_bits,
    input  wire logic [4:0]                 i_num_hashes,
    output logic                            o_busy,
    bfaq_rsp_if.source                      rsp
);
    import bfaq_pkg::*;

    t_back_state         r_state, n_state;
    logic                r_clr;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [31:0]         r_h1, r_h2, r_val;
    logic                r_cmd, r_all;
    logic [KCNT_W-1:0]   r_i, r_k;
    logic [16:0]         r_m;
    logic [5:0]          r_bit;
    logic [31:0]         r_rem;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_store [MAX_BITS];
    logic                r_rd;
    logic                r_out_v, r_out_q, r_out_p;
    logic [31:0]         w_prod;
    logic [32:0]         w_trial;
    logic [31:0]         w_rem_sh;
    logic                w_wr;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_wr_addr;

    assign w_prod   = 32'(r_i) * r_h2;
    assign w_rem_sh = {r_rem[30:0], r_val[31]};
    assign w_trial  = {r_rem[31], w_rem_sh} - {16'd0, r_m};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MAX_BITS - 1)) r_clr <= 1'b0;
            end
            if (r_state == B_DONE && (!r_out_v || rsp.ready)) r_out_v <= 1'b1;
            else if (rsp.valid && rsp.ready) r_out_v <= 1'b0;
            unique case (r_state)
                B_IDLE: if (!r_clr && i_valid) begin
                    r_state <= B_PROD;
                end
                B_PROD: r_state <= (r_i == r_k) ? B_DONE : B_MOD;
                B_MOD: if (r_bit == 6'd0) r_state <= B_ACCESS;
                B_ACCESS: r_state <= B_CHECK;
                B_CHECK: r_state <= B_PROD;
                B_DONE: if (!r_out_v || rsp.ready) begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
        unique case (r_state)
            B_IDLE: begin
                r_h1  <= i_job.h1;
                r_h2  <= i_job.h2;
                r_cmd <= i_job.cmd;
                r_all <= 1'b1;
                r_i   <= '0;
                r_m   <= (i_num_bits > 17'(MAX_BITS)) ? 17'(MAX_BITS) : i_num_bits;
                r_k   <= (i_num_bits == 17'd0) ? '0 :
                         ((i_num_hashes > 5'(MAX_HASHES)) ? KCNT_W'(MAX_HASHES)
                                                          : KCNT_W'(i_num_hashes));
            end
            B_PROD: begin
                r_val <= r_h1 + w_prod;
                r_rem <= '0;
                r_bit <= 6'd32;
            end
            B_MOD: if (r_bit != 6'd0) begin
                r_val <= {r_val[30:0], 1'b0};
                r_bit <= r_bit - 1'b1;
                if (!w_trial[32]) r_rem <= w_trial[31:0];
                else r_rem <= w_rem_sh;
            end else begin
                r_addr <= r_rem[ADDR_W-1:0];
            end
            B_CHECK: begin
                if (!r_rd) r_all <= 1'b0;
                r_i <= r_i + 1'b1;
            end
            B_DONE: if (!r_out_v || rsp.ready) begin
                r_out_q <= r_cmd;
                r_out_p <= (r_cmd == CMD_QUERY) && r_all;
            end
            default: ;
        endcase
    end

    assign w_wr      = r_clr || (r_state == B_ACCESS && r_cmd == CMD_ADD);
    assign w_wr_addr = r_clr ? r_clr_addr : r_addr;
    assign w_rd_en   = (r_state == B_ACCESS);

    always_ff @(posedge i_clk) begin
        if (w_wr) r_store[w_wr_addr] <= !r_clr;
        if (w_rd_en) r_rd <= r_store[r_addr];
    end

    assign o_ready           = (r_state == B_IDLE) && !r_clr;
    assign o_busy            = (r_state != B_IDLE) || r_out_v;
    assign rsp.valid         = r_out_v;
    assign rsp.was_query     = r_out_q;
    assign rsp.maybe_present = r_out_p;

`ifndef SYNTHESIS
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (r_state == B_IDLE)) else $error("job taken during clear");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= r_k || r_state == B_IDLE) else $error("probe count overrun");
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_q) |-> !r_out_p) else $error("add reported present");
`endif
endmodule
`default_nettype wire

@@ rtl/core/bloom_filter_add_query_core.sv @@
// Top level of the Bloom filter core: APB registers, front end, queue and back end.
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | cmd, key_byte, has_byte, last
//  rsp     | out | valid/ready     | was_query, maybe_present
//  apb     | in  | psel/penable    | paddr, pwdata (prdata out)
// A key byte passes through the front end states S_IDLE, S_MIX1 and S_MIX2 (one hash multiply round each).
// Each probe of a key end runs B_PROD, B_MOD (bit-serial modulo), B_ACCESS and B_CHECK in the back end.
// After reset the back end clears all 65536 bits of the bit store; it takes no key end then.
// The job queue holds 4 key ends so the front end keeps hashing while probes run.
`default_nettype none
module bloom_filter_add_query_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bfaq_req_if.sink         req,
    bfaq_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bfaq_pkg::*;

    logic [16:0] r_num_bits;
    logic [4:0]  r_num_hashes;
    t_job        w_fjob, w_qjob;
    logic        w_fvalid, w_fready, w_qvalid, w_qready, w_busy;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= 17'd65536;
            r_num_hashes <= 5'd7;
        end else if (w_wr) begin
            unique case ({1'b0, paddr[2]})
                REG_NUM_BITS:   r_num_bits   <= pwdata[16:0];
                REG_NUM_HASHES: r_num_hashes <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case ({1'b0, paddr[2]})
            REG_NUM_BITS:   prdata = {15'd0, r_num_bits};
            REG_NUM_HASHES: prdata = {27'd0, r_num_hashes};
            default:        prdata = '0;
        endcase
    end

    bfaq_front u_front (
        .i_clk, .i_rst_n, .req,
        .o_job(w_fjob), .o_job_valid(w_fvalid), .i_job_ready(w_fready)
    );

    bfaq_queue u_queue (
        .i_clk, .i_rst_n,
        .i_job(w_fjob), .i_valid(w_fvalid), .o_ready(w_fready),
        .o_job(w_qjob), .o_valid(w_qvalid), .i_ready(w_qready)
    );

    bfaq_back u_back (
        .i_clk, .i_rst_n,
        .i_job(w_qjob), .i_valid(w_qvalid), .o_ready(w_qready),
        .i_num_bits(r_num_bits), .i_num_hashes(r_num_hashes),
        .o_busy(w_busy), .rsp
    );

`ifndef SYNTHESIS
    a_busy_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> w_busy) else $error("result shown while back end idle");
    a_q_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qvalid && w_qready) |=> w_busy) else $error("job lost in back end");
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
`endif
endmodule
`default_nettype wire

@@ tb/tb_bfaq_pkg.sv @@
// Testbench-only types: one key request item and one expected filter answer.
`timescale 1ns / 100ps
package tb_bfaq_pkg;
    typedef struct {
        logic       cmd;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last;
    } t_key_req;

    typedef struct {
        logic was_query;
        logic maybe_present;
    } t_answer;
endpackage

@@ tb/tb_bloom_filter_add_query_core.sv @@
// Self-checking testbench for the Bloom filter add/query core with a built-in hash and bit model.
`timescale 1ns / 100ps
module tb_bloom_filter_add_query_core;
    import bfaq_pkg::*;
    import tb_bfaq_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bfaq_req_if req_if (i_clk);
    bfaq_rsp_if rsp_if (i_clk);

    bloom_filter_add_query_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_key_req    pending_reqs[$];
    t_answer     expected_answers[$];
    bit          filter_model[MAX_BITS];
    logic [31:0] fnv_acc;
    logic [31:0] mix_acc;
    logic [16:0] cfg_bits;
    logic [4:0]  cfg_hashes;
    int          errors;
    int          keys_done;
    int          queries_hit;
    bit          quiet;
    int          src_gap;
    int          snk_gap;
    logic [7:0]  saved_keys[64][8];
    int          saved_len[64];
    int          saved_cnt;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [31:0] mix_round(input logic [31:0] h);
        logic [31:0] r;
        r = (h ^ (h >> 16)) * MIX_MUL;
        return r;
    endfunction

    function automatic t_answer filter_step(input t_key_req it);
        t_answer     ans;
        logic [31:0] m;
        logic [31:0] k;
        logic [31:0] pos;
        logic [31:0] h;
        bit          all_set;
        all_set = 1'b1;
        if (it.has_byte) begin
            fnv_acc = (fnv_acc ^ {24'd0, it.key_byte}) * FNV_PRIME;
            h = mix_round(mix_round(mix_acc ^ {24'd0, it.key_byte}));
            mix_acc = h ^ (h >> 16);
        end
        m = (cfg_bits > MAX_BITS) ? MAX_BITS : {15'd0, cfg_bits};
        k = (cfg_hashes > MAX_HASHES) ? MAX_HASHES : {27'd0, cfg_hashes};
        if (m != 0) begin
            for (int i = 0; i < k; i++) begin
                pos = (fnv_acc + 32'(i) * mix_acc) % m;
                if (it.cmd == CMD_ADD) filter_model[pos] = 1'b1;
                else if (!filter_model[pos]) all_set = 1'b0;
            end
        end
        ans.was_query = it.cmd;
        ans.maybe_present = (it.cmd == CMD_QUERY) && all_set;
        return ans;
    endfunction

    // Request driver with random source gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            src_gap <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                src_gap <= $urandom_range(0, 17);
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_key_req it;
                it = pending_reqs.pop_front();
                req_if.valid    <= 1'b1;
                req_if.cmd      <= it.cmd;
                req_if.key_byte <= it.key_byte;
                req_if.has_byte <= it.has_byte;
                req_if.last     <= it.last;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result ready with random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            snk_gap <= 0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            snk_gap <= $urandom_range(0, 17);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                t_key_req it;
                it.cmd = req_if.cmd;
                it.key_byte = req_if.key_byte;
                it.has_byte = req_if.has_byte;
                it.last = req_if.last;
                if (it.last) begin
                    expected_answers.push_back(filter_step(it));
                    fnv_acc = FNV_OFFSET;
                    mix_acc = MIX_SEED;
                end else if (it.has_byte) begin
                    void'(filter_step('{cmd: CMD_QUERY, key_byte: it.key_byte,
                                        has_byte: 1'b1, last: 1'b0}));
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                t_answer exp_ans;
                if (expected_answers.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    exp_ans = expected_answers.pop_front();
                    keys_done++;
                    if (rsp_if.was_query !== exp_ans.was_query)
                        report_mismatch($sformatf("was_query %b, expected %b",
                                                  rsp_if.was_query, exp_ans.was_query));
                    if (rsp_if.maybe_present !== exp_ans.maybe_present)
                        report_mismatch($sformatf("maybe_present %b, expected %b",
                                                  rsp_if.maybe_present,
                                                  exp_ans.maybe_present));
                    if (exp_ans.maybe_present) queries_hit++;
                end
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] b, input logic hb,
                             input logic last);
        pending_reqs.push_back('{cmd: cmd, key_byte: b, has_byte: hb, last: last});
    endtask

    // A key: its bytes with optional noise items without a byte, closed by the last byte or a closing item.
    task automatic push_key(input logic cmd, input int len, input int slot);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1) == 0)
                push_item(cmd, saved_keys[slot][i], 1'b1, 1'b1);
            else
                push_item(1'($urandom_range(0, 1)), saved_keys[slot][i], 1'b1, 1'b0);
        end
        if (len == 0 || pending_reqs[$].last == 1'b0)
            push_item(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic random_keys(input int n);
        int slot;
        int len;
        for (int j = 0; j < n; j++) begin
            if (saved_cnt > 0 && $urandom_range(0, 2) == 0) begin
                slot = $urandom_range(0, saved_cnt - 1);
                push_key($urandom_range(0, 3) == 0 ? CMD_ADD : CMD_QUERY,
                         saved_len[slot], slot);
            end else begin
                slot = (saved_cnt < 63) ? saved_cnt : 63;
                len = $urandom_range(0, 8);
                saved_len[slot] = len;
                for (int i = 0; i < 8; i++) saved_keys[slot][i] = 8'($urandom_range(0, 255));
                if (saved_cnt < 63) saved_cnt++;
                push_key($urandom_range(0, 1) ? CMD_ADD : CMD_QUERY, len, slot);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_answers.size() != 0 || req_if.valid)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NUM_BITS) cfg_bits = val[16:0];
        else if (idx == REG_NUM_HASHES) cfg_hashes = val[4:0];
    endtask

    task automatic configure(input logic [31:0] m, input logic [31:0] k);
        wait_drained();
        reg_write(REG_NUM_BITS, m);
        reg_write(REG_NUM_HASHES, k);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.cmd = 1'b0;
        req_if.key_byte = '0;
        req_if.has_byte = 1'b0;
        req_if.last = 1'b0;
        rsp_if.ready = 1'b0;
        errors = 0;
        keys_done = 0;
        queries_hit = 0;
        quiet = 1'b0;
        saved_cnt = 0;
        fnv_acc = FNV_OFFSET;
        mix_acc = MIX_SEED;
        cfg_bits = 17'd65536;
        cfg_hashes = 5'd7;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed keys: empty key, extreme bytes, both commands, noise items.
        push_item(CMD_QUERY, 8'h00, 1'b0, 1'b1);
        push_item(CMD_ADD, 8'hFF, 1'b0, 1'b1);
        push_item(CMD_QUERY, 8'h5A, 1'b0, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_ADD, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b0);
        push_item(CMD_ADD, 8'hAA, 1'b0, 1'b0);
        push_item(CMD_ADD, 8'h00, 1'b1, 1'b1);
        push_item(CMD_ADD, 8'h00, 1'b1, 1'b0);
        push_item(CMD_ADD, 8'h55, 1'b0, 1'b0);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'h01, 1'b1, 1'b1);
        random_keys(60);

        configure(0, 3);
        push_item(CMD_QUERY, 8'h12, 1'b1, 1'b1);
        push_item(CMD_ADD, 8'h12, 1'b1, 1'b1);
        random_keys(25);

        configure(1, 1);
        random_keys(25);

        configure(32'h1FFFF, 31);
        random_keys(50);

        configure(65536, 0);
        push_item(CMD_QUERY, 8'h77, 1'b1, 1'b1);
        random_keys(25);

        configure(100, 16);
        random_keys(60);

        configure(65535, 17);
        random_keys(40);

        configure($urandom_range(2, 5000), $urandom_range(1, 8));
        random_keys(60);

        configure(8, 2);
        random_keys(40);

        configure($urandom_range(1000, 70000), $urandom_range(1, 16));
        quiet = 1'b1;
        random_keys(50);

        wait_drained();
        repeat (1000) @(posedge i_clk);
        $display("Checked %0d key results (%0d positive queries) over 10 size/probe settings,",
                 keys_done, queries_hit);
        $display("including zero bits, zero probes and oversized settings.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d results outstanding", expected_answers.size());
        $display("Verification failed");
        $finish;
    end
endmodule
